// File: design/hlc_pkg.sv
`timescale 1ns / 1ps
// Package with shared constants, types and register codes for the line clipper.
package hlc_pkg;
   localparam int COORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int PARAM_FRAC_BITS_DEF = 16;
   localparam int MIN_DEN_BITS = 31;
   localparam int PLANES = 6;
   localparam int CSR_ADDR_BITS = 3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MIN_DEN = 3'd0;
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic push;
      logic pop;
   } hlc_queue_ctl_type;
endpackage

// File: design/hlc_front.sv
`timescale 1ns / 1ps
// Front part: computes plane distances of both ends and registers both end points.
module hlc_front #(
   parameter int COORD_BITS = hlc_pkg::COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic signed [COORD_BITS-1:0] sx, sy, sz, sw, ex, ey, ez, ew,
   output logic out_valid,
   output logic signed [COORD_BITS+1:0] da [6],
   output logic signed [COORD_BITS+1:0] db [6],
   output logic [4*COORD_BITS-1:0] ps_out,
   output logic [4*COORD_BITS-1:0] pe_out
);
   import hlc_pkg::*;
   localparam int DW = COORD_BITS + 2;
   logic valid_ff;
   logic signed [DW-1:0] da_ff [6];
   logic signed [DW-1:0] db_ff [6];
   logic [4*COORD_BITS-1:0] ps_ff, pe_ff;
   logic signed [DW-1:0] s_ext [4];
   logic signed [DW-1:0] e_ext [4];

   always_comb begin
      s_ext[0] = DW'(sx); s_ext[1] = DW'(sy); s_ext[2] = DW'(sz); s_ext[3] = DW'(sw);
      e_ext[0] = DW'(ex); e_ext[1] = DW'(ey); e_ext[2] = DW'(ez); e_ext[3] = DW'(ew);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      for (int k = 0; k < 3; k++) begin
         da_ff[2*k]   <= s_ext[3] + s_ext[k];
         da_ff[2*k+1] <= s_ext[3] - s_ext[k];
         db_ff[2*k]   <= e_ext[3] + e_ext[k];
         db_ff[2*k+1] <= e_ext[3] - e_ext[k];
      end
      ps_ff <= {sw, sz, sy, sx};
      pe_ff <= {ew, ez, ey, ex};
   end

   assign out_valid = valid_ff;
   assign da = da_ff;
   assign db = db_ff;
   assign ps_out = ps_ff;
   assign pe_out = pe_ff;
endmodule

// File: design/hlc_queue.sv
`timescale 1ns / 1ps
// Short register queue between the front and the back parts.
module hlc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = hlc_pkg::QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  hlc_pkg::hlc_queue_ctl_type ctl,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data,
   output logic not_empty
);
   import hlc_pkg::*;
   localparam int AW = $clog2(DEPTH);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (ctl.push) wp_ff <= wp_ff + 1'b1;
         if (ctl.pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(ctl.push) - (AW+1)'(ctl.pop);
      end
      if (ctl.push) mem_ff[wp_ff] <= wr_data;
   end

   assign rd_data = mem_ff[rp_ff];
   assign not_empty = (cnt_ff != '0);
endmodule

// File: design/hlc_back.sv
`timescale 1ns / 1ps
// Back part: pipelined crossing divisions, enter/exit tracking and interpolation.
module hlc_back #(
   parameter int COORD_BITS = hlc_pkg::COORD_BITS_DEF,
   parameter int PARAM_FRAC_BITS = hlc_pkg::PARAM_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [hlc_pkg::MIN_DEN_BITS-1:0] min_den,
   input  logic [12*(COORD_BITS+2)-1:0] dist_in,
   input  logic [8*COORD_BITS-1:0] pts_in,
   output logic out_valid,
   output logic out_visible,
   output logic [8*COORD_BITS-1:0] pts_out
);
   import hlc_pkg::*;
   localparam int DW = COORD_BITS + 2;
   localparam int P = PARAM_FRAC_BITS;
   localparam int TW = P + 1;
   localparam int ND = P + 1;
   localparam int DIFW = COORD_BITS + 1;
   localparam int PW = DIFW + TW;

   // stage 0: per-plane classification and denominators
   logic v0_ff, ok0_ff;
   logic [5:0] act0_ff, ent0_ff;
   logic [DW-1:0] num0_ff [6];
   logic [DW-1:0] den0_ff [6];
   logic [8*COORD_BITS-1:0] pts0_ff;

   always_ff @(posedge clock) begin
      logic signed [DW-1:0] a, b;
      logic signed [DW:0] d;
      logic [DW:0] dm;
      logic ok;
      if (reset) v0_ff <= 1'b0;
      else v0_ff <= in_valid;
      ok = 1'b1;
      for (int i = 0; i < 6; i++) begin
         a = dist_in[i*DW +: DW];
         b = dist_in[(6+i)*DW +: DW];
         d = (DW+1)'(a) - (DW+1)'(b);
         dm = d[DW] ? (DW+1)'(-d) : (DW+1)'(d);
         act0_ff[i] <= a[DW-1] ^ b[DW-1];
         ent0_ff[i] <= a[DW-1];
         if (a[DW-1] && b[DW-1]) ok = 1'b0;
         if ((a[DW-1] ^ b[DW-1]) && dm <= (DW+1)'(min_den)) ok = 1'b0;
         num0_ff[i] <= a[DW-1] ? DW'(-a) : DW'(a);
         den0_ff[i] <= DW'(dm);
      end
      ok0_ff <= ok;
      pts0_ff <= pts_in;
   end

   // divider pipeline: one quotient bit per stage for all six planes
   logic v_ff [ND];
   logic ok_ff [ND];
   logic [5:0] act_ff [ND];
   logic [5:0] ent_ff [ND];
   logic [DW:0] rem_ff [ND][6];
   logic [DW-1:0] den_ff [ND][6];
   logic [TW-1:0] q_ff [ND][6];
   logic [8*COORD_BITS-1:0] pts_ff [ND];

   for (genvar s = 0; s < ND; s++) begin : g_div
      localparam int SP = (s == 0) ? 0 : s - 1;
      always_ff @(posedge clock) begin
         logic [DW:0] r;
         logic [DW:0] rs;
         if (reset) v_ff[s] <= 1'b0;
         else v_ff[s] <= (s == 0) ? v0_ff : v_ff[SP];
         for (int i = 0; i < 6; i++) begin
            if (s == 0) begin
               r = (DW+1)'(num0_ff[i]);
               den_ff[s][i] <= den0_ff[i];
               if (r >= (DW+1)'(den0_ff[i])) begin
                  rem_ff[s][i] <= r - (DW+1)'(den0_ff[i]);
                  q_ff[s][i] <= TW'(1);
               end else begin
                  rem_ff[s][i] <= r;
                  q_ff[s][i] <= '0;
               end
            end else begin
               rs = rem_ff[SP][i] << 1;
               den_ff[s][i] <= den_ff[SP][i];
               if (rs >= (DW+1)'(den_ff[SP][i])) begin
                  rem_ff[s][i] <= rs - (DW+1)'(den_ff[SP][i]);
                  q_ff[s][i] <= {q_ff[SP][i][TW-2:0], 1'b1};
               end else begin
                  rem_ff[s][i] <= rs;
                  q_ff[s][i] <= {q_ff[SP][i][TW-2:0], 1'b0};
               end
            end
         end
         ok_ff[s] <= (s == 0) ? ok0_ff : ok_ff[SP];
         act_ff[s] <= (s == 0) ? act0_ff : act_ff[SP];
         ent_ff[s] <= (s == 0) ? ent0_ff : ent_ff[SP];
         pts_ff[s] <= (s == 0) ? pts0_ff : pts_ff[SP];
      end
   end

   // enter/exit reduction over six planes in plane order
   logic vr_ff, okr_ff;
   logic [TW-1:0] ten_ff, tex_ff;
   logic [8*COORD_BITS-1:0] ptsr_ff;

   always_ff @(posedge clock) begin
      logic [TW-1:0] en, ex;
      logic ok;
      if (reset) vr_ff <= 1'b0;
      else vr_ff <= v_ff[ND-1];
      en = '0;
      ex = TW'(1) << P;
      ok = ok_ff[ND-1];
      for (int i = 0; i < 6; i++) begin
         if (act_ff[ND-1][i]) begin
            if (ent_ff[ND-1][i]) begin
               if (q_ff[ND-1][i] > en) en = q_ff[ND-1][i];
            end else begin
               if (q_ff[ND-1][i] < ex) ex = q_ff[ND-1][i];
            end
            if (en > ex) ok = 1'b0;
         end
      end
      okr_ff <= ok;
      ten_ff <= en;
      tex_ff <= ex;
      ptsr_ff <= pts_ff[ND-1];
   end

   // differences
   logic vd_ff, okd_ff;
   logic [TW-1:0] tend_ff, texd_ff;
   logic signed [DIFW-1:0] dif_ff [4];
   logic [8*COORD_BITS-1:0] ptsd_ff;

   always_ff @(posedge clock) begin
      if (reset) vd_ff <= 1'b0;
      else vd_ff <= vr_ff;
      for (int i = 0; i < 4; i++) begin
         dif_ff[i] <= DIFW'($signed(ptsr_ff[(4+i)*COORD_BITS +: COORD_BITS]))
                    - DIFW'($signed(ptsr_ff[i*COORD_BITS +: COORD_BITS]));
      end
      okd_ff <= okr_ff;
      tend_ff <= ten_ff;
      texd_ff <= tex_ff;
      ptsd_ff <= ptsr_ff;
   end

   // products
   logic vm_ff, okm_ff;
   logic signed [PW-1:0] ps_ff [4];
   logic signed [PW-1:0] pe_ff [4];
   logic [8*COORD_BITS-1:0] ptsm_ff;

   always_ff @(posedge clock) begin
      if (reset) vm_ff <= 1'b0;
      else vm_ff <= vd_ff;
      for (int i = 0; i < 4; i++) begin
         ps_ff[i] <= PW'(dif_ff[i]) * $signed({1'b0, tend_ff});
         pe_ff[i] <= PW'(dif_ff[i]) * $signed({1'b0, texd_ff});
      end
      okm_ff <= okd_ff;
      ptsm_ff <= ptsd_ff;
   end

   // final add and select
   logic vo_ff, viso_ff;
   logic [8*COORD_BITS-1:0] ptso_ff;

   always_ff @(posedge clock) begin
      logic signed [PW-1:0] sh_s, sh_e;
      if (reset) vo_ff <= 1'b0;
      else vo_ff <= vm_ff;
      viso_ff <= okm_ff;
      for (int i = 0; i < 4; i++) begin
         sh_s = ps_ff[i] >>> P;
         sh_e = pe_ff[i] >>> P;
         if (okm_ff) begin
            ptso_ff[i*COORD_BITS +: COORD_BITS] <=
               ptsm_ff[i*COORD_BITS +: COORD_BITS] + sh_s[COORD_BITS-1:0];
            ptso_ff[(4+i)*COORD_BITS +: COORD_BITS] <=
               ptsm_ff[i*COORD_BITS +: COORD_BITS] + sh_e[COORD_BITS-1:0];
         end else begin
            ptso_ff[i*COORD_BITS +: COORD_BITS] <= ptsm_ff[i*COORD_BITS +: COORD_BITS];
            ptso_ff[(4+i)*COORD_BITS +: COORD_BITS] <=
               ptsm_ff[(4+i)*COORD_BITS +: COORD_BITS];
         end
      end
   end

   assign out_valid = vo_ff;
   assign out_visible = viso_ff;
   assign pts_out = ptso_ff;

   a_enter_le_exit: assert property (@(posedge clock) disable iff (reset)
      vr_ff && okr_ff |-> ten_ff <= tex_ff) else $error("enter past exit on visible");
   a_exit_bound: assert property (@(posedge clock) disable iff (reset)
      vr_ff |-> tex_ff <= (TW'(1) << P)) else $error("exit above one");
   a_valid_flow: assert property (@(posedge clock) disable iff (reset)
      vm_ff |=> vo_ff) else $error("request lost in back end");
endmodule

// File: design/homogeneous_line_clipper_unit.sv
`timescale 1ns / 1ps
// Top level of the homogeneous line clipper with its register port.
// Start reaches rsp_strobe through the front, queue, divider and back-end registers.
// Throughput: one request per cycle; busy stays low, set by the fully pipelined divider.
// Each result shows on the rsp_ ports for one cycle; the receiver cannot stall.
// Synchronous active-high reset clears all valid flags and min_denominator.
module homogeneous_line_clipper_unit #(
   parameter int COORD_BITS = hlc_pkg::COORD_BITS_DEF,
   parameter int PARAM_FRAC_BITS = hlc_pkg::PARAM_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [COORD_BITS-1:0] req_start_x, req_start_y, req_start_z, req_start_w,
   input  logic signed [COORD_BITS-1:0] req_end_x, req_end_y, req_end_z, req_end_w,
   output logic rsp_strobe,
   output logic rsp_visible,
   output logic signed [COORD_BITS-1:0] rsp_clip_start_x, rsp_clip_start_y,
   output logic signed [COORD_BITS-1:0] rsp_clip_start_z, rsp_clip_start_w,
   output logic signed [COORD_BITS-1:0] rsp_clip_end_x, rsp_clip_end_y,
   output logic signed [COORD_BITS-1:0] rsp_clip_end_z, rsp_clip_end_w,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [hlc_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   import hlc_pkg::*;
   localparam int DW = COORD_BITS + 2;
   localparam int QW = 12*DW + 8*COORD_BITS;

   logic [MIN_DEN_BITS-1:0] min_den_ff;
   always_ff @(posedge clock) begin
      if (reset) min_den_ff <= '0;
      else if (psel && penable && pwrite && pready && paddr == CSR_MIN_DEN)
         min_den_ff <= pwdata[MIN_DEN_BITS-1:0];
   end
   assign pready = 1'b1;
   assign prdata = (paddr == CSR_MIN_DEN) ? {1'b0, min_den_ff} : '0;

   logic accept;
   assign busy = 1'b0;
   assign accept = start && !busy;

   logic f_valid;
   logic signed [DW-1:0] da [6];
   logic signed [DW-1:0] db [6];
   logic [4*COORD_BITS-1:0] ps, pe;

   hlc_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock, .reset, .in_valid(accept),
      .sx(req_start_x), .sy(req_start_y), .sz(req_start_z), .sw(req_start_w),
      .ex(req_end_x), .ey(req_end_y), .ez(req_end_z), .ew(req_end_w),
      .out_valid(f_valid), .da, .db, .ps_out(ps), .pe_out(pe)
   );

   logic [QW-1:0] q_wr, q_rd;
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         q_wr[i*DW +: DW] = da[i];
         q_wr[(6+i)*DW +: DW] = db[i];
      end
      q_wr[12*DW +: 8*COORD_BITS] = {pe, ps};
   end

   hlc_queue_ctl_type qctl;
   logic q_ne;
   assign qctl.push = f_valid;
   assign qctl.pop = q_ne;

   hlc_queue #(.WIDTH(QW)) u_queue (
      .clock, .reset, .ctl(qctl), .wr_data(q_wr), .rd_data(q_rd), .not_empty(q_ne)
   );

   logic [8*COORD_BITS-1:0] pts_out;
   hlc_back #(.COORD_BITS(COORD_BITS), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_back (
      .clock, .reset, .in_valid(q_ne), .min_den(min_den_ff),
      .dist_in(q_rd[12*DW-1:0]), .pts_in(q_rd[12*DW +: 8*COORD_BITS]),
      .out_valid(rsp_strobe), .out_visible(rsp_visible), .pts_out(pts_out)
   );

   assign rsp_clip_start_x = pts_out[0*COORD_BITS +: COORD_BITS];
   assign rsp_clip_start_y = pts_out[1*COORD_BITS +: COORD_BITS];
   assign rsp_clip_start_z = pts_out[2*COORD_BITS +: COORD_BITS];
   assign rsp_clip_start_w = pts_out[3*COORD_BITS +: COORD_BITS];
   assign rsp_clip_end_x = pts_out[4*COORD_BITS +: COORD_BITS];
   assign rsp_clip_end_y = pts_out[5*COORD_BITS +: COORD_BITS];
   assign rsp_clip_end_z = pts_out[6*COORD_BITS +: COORD_BITS];
   assign rsp_clip_end_w = pts_out[7*COORD_BITS +: COORD_BITS];
endmodule
